@@ rtl/assert_macros.svh @@
// Assertion helpers used by the lfbp_checker module.
// Each assertion samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define LFBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lfbp assertion failed");

// The condition must never be seen at a clock edge outside reset.
`define LFBP_ASSERT_NEVER(lbl, cond) `LFBP_ASSERT(lbl, !(cond))

`endif

@@ rtl/lfbp_pkg.sv @@
package lfbp_pkg;

  localparam int MAX_CODE_BITS = 16;
  localparam int CODE_W        = 16;
  localparam int LEN_W         = 5;
  localparam int LEN_LIMIT     = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  // Up to seven pending bits plus the longest code.
  localparam int ACC_W         = LEN_LIMIT + 7;
  localparam int HELD_W        = 5;
  localparam int CAP_W         = 16;
  localparam int BYTE_W        = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = '1;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // One queued job: one or two results for a single request.
  typedef struct packed {
    logic              two;
    logic [BYTE_W-1:0] byte0;
    logic              err0;
    logic [BYTE_W-1:0] byte1;
    logic              err1;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/lfbp_queue.sv @@
module lfbp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lfbp_pkg::job_t     job_i,
  input  logic               pop_i,
  output lfbp_pkg::job_t     job_o,
  output lfbp_pkg::q_stat_t  stat_o
);

  lfbp_pkg::job_t                 mem_q [lfbp_pkg::QDEPTH];
  logic [lfbp_pkg::PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lfbp_pkg::PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lfbp_pkg::CNT_W-1:0]     cnt_q, cnt_d;

  localparam logic [lfbp_pkg::PTR_W-1:0] LastPtr = lfbp_pkg::PTR_W'(lfbp_pkg::QDEPTH - 1);

  assign stat_o.full  = (cnt_q == lfbp_pkg::CNT_W'(lfbp_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign job_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ rtl/lfbp_front.sv @@
module lfbp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfbp_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lfbp_pkg::CODE_W-1:0]     code_bits_i,
  input  logic [lfbp_pkg::LEN_W-1:0]      code_length_i,
  input  logic                            reverse_i,
  input  lfbp_pkg::q_stat_t               q_stat_i,
  output logic                            push_o,
  output lfbp_pkg::job_t                  job_o
);

  logic [lfbp_pkg::CAP_W-1:0]  cap_q;
  logic [lfbp_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [lfbp_pkg::HELD_W-1:0] held_q, held_d;
  logic [lfbp_pkg::CAP_W-1:0]  pos_q, pos_d;
  logic                        full_q, full_d;

  logic                          accept;
  logic [lfbp_pkg::LEN_W-1:0]    len_sat;
  logic [lfbp_pkg::LEN_W-1:0]    shamt;
  logic [lfbp_pkg::CODE_W-1:0]   mask, code_m, rev_full, code_r, code_v;
  logic [lfbp_pkg::ACC_W-1:0]    merged;
  logic [lfbp_pkg::HELD_W-1:0]   total;
  logic [1:0]                    nbytes;
  logic [lfbp_pkg::CAP_W-1:0]    pos_p1;
  logic                          e0, e1;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !q_stat_i.full;

  // Saturate the length, mask the value, and mirror it when asked.
  assign len_sat = (code_length_i > lfbp_pkg::LEN_W'(lfbp_pkg::LEN_LIMIT)) ?
                   lfbp_pkg::LEN_W'(lfbp_pkg::LEN_LIMIT) : code_length_i;
  assign mask    = ~({lfbp_pkg::CODE_W{1'b1}} << len_sat);
  assign code_m  = code_bits_i & mask;

  always_comb begin
    for (int i = 0; i < lfbp_pkg::CODE_W; i++) begin
      rev_full[i] = code_m[lfbp_pkg::CODE_W-1-i];
    end
  end

  assign shamt  = lfbp_pkg::LEN_W'(lfbp_pkg::CODE_W) - len_sat;
  assign code_r = rev_full >> shamt;
  assign code_v = reverse_i ? code_r : code_m;

  assign merged = acc_q | (lfbp_pkg::ACC_W'(code_v) << held_q);
  assign total  = held_q + lfbp_pkg::HELD_W'(len_sat);
  assign nbytes = total[lfbp_pkg::HELD_W-1:3];
  assign pos_p1 = pos_q + 1'b1;
  assign e0     = (pos_q >= cap_q);
  assign e1     = (pos_p1 >= cap_q);

  always_comb begin
    acc_d  = acc_q;
    held_d = held_q;
    pos_d  = pos_q;
    full_d = full_q;
    push_o = 1'b0;
    job_o  = '0;
    if (accept) begin
      if (full_q) begin
        push_o     = 1'b1;
        job_o.err0 = 1'b1;
      end else if (nbytes == 2'd0) begin
        acc_d  = merged;
        held_d = total;
      end else begin
        push_o = 1'b1;
        if (e0) begin
          job_o.err0 = 1'b1;
          full_d     = 1'b1;
        end else begin
          job_o.byte0 = merged[7:0];
          if (!nbytes[1]) begin
            pos_d  = pos_p1;
            held_d = total - lfbp_pkg::HELD_W'(8);
            acc_d  = merged >> 8;
          end else begin
            job_o.two = 1'b1;
            pos_d     = pos_p1;
            if (e1) begin
              job_o.err1 = 1'b1;
              full_d     = 1'b1;
            end else begin
              job_o.byte1 = merged[15:8];
              pos_d       = pos_q + 2'd2;
              held_d      = total - lfbp_pkg::HELD_W'(16);
              acc_d       = merged >> 16;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= lfbp_pkg::CAP_RESET;
      acc_q  <= '0;
      held_q <= '0;
      pos_q  <= '0;
      full_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      acc_q  <= acc_d;
      held_q <= held_d;
      pos_q  <= pos_d;
      full_q <= full_d;
    end
  end

endmodule

@@ rtl/lfbp_back.sv @@
module lfbp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lfbp_pkg::job_t               job_i,
  input  lfbp_pkg::q_stat_t            q_stat_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lfbp_pkg::BYTE_W-1:0]  byte_out_o,
  output logic                         is_error_o,
  output logic                         last_o
);

  logic                        sel_q, sel_d;
  logic                        out_valid_q;
  logic [lfbp_pkg::BYTE_W-1:0] byte_q;
  logic                        err_q, last_q;
  logic                        load;

  // The output register takes the next result whenever it is empty or drained.
  assign load  = !q_stat_i.empty && (!out_valid_q || out_ready_i);
  assign pop_o = load && (sel_q || !job_i.two);
  assign sel_d = load ? !pop_o : sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_q ? job_i.byte1 : job_i.byte0;
      err_q  <= sel_q ? job_i.err1 : job_i.err0;
      last_q <= sel_q || !job_i.two;
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = byte_q;
  assign is_error_o  = err_q;
  assign last_o      = last_q;

endmodule

@@ rtl/lsb_first_bit_packer.sv @@
// LSB-first bit packer for Deflate-style streams.
// Input channel (in_valid_i/in_ready_o): each request carries code_bits_i, a
// length code_length_i of 0 to 16 and a reverse_i flag that mirrors the code.
// Lengths above 16 are treated as 16. Bits are packed oldest first and every
// completed byte leaves on the output channel (out_valid_o/out_ready_i) with
// is_error_o low; last_o marks the final result of a request.
// Once the byte count reaches capacity, one error result is sent and every
// later request answers with a single error result and its bits are dropped.
// Only reset clears that state. The user must write the capacity through
// cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it. Before
// the full state, a request that completes no byte produces no result.
// The first result of a request passes through the job queue and then the
// output register before it is valid. A request is taken every cycle while
// the job queue has room; a request that completes two bytes holds the output
// port for both results, so the output port limits the sustained request rate.
// When the receiver stalls, results wait in the output register and the
// two-entry job queue; in_ready_o drops once that queue is full.
// Reset clears the packed bits, the byte count and the error state, and sets
// the capacity to 65535.
module lsb_first_bit_packer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfbp_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lfbp_pkg::CODE_W-1:0]     code_bits_i,
  input  logic [lfbp_pkg::LEN_W-1:0]      code_length_i,
  input  logic                            reverse_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lfbp_pkg::BYTE_W-1:0]     byte_out_o,
  output logic                            is_error_o,
  output logic                            last_o
);

  // The front end packs bits and decides each request's results in the cycle
  // it is accepted; the back end replays them one per cycle while the receiver takes them.
  logic              push, pop;
  lfbp_pkg::job_t    job_in, job_head;
  lfbp_pkg::q_stat_t q_stat;

  lfbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .reverse_i     (reverse_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .job_o         (job_in)
  );

  lfbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_head),
    .stat_o (q_stat)
  );

  lfbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .byte_out_o  (byte_out_o),
    .is_error_o  (is_error_o),
    .last_o      (last_o)
  );

endmodule

@@ rtl/lfbp_checker.sv @@
`include "assert_macros.svh"

module lfbp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [lfbp_pkg::BYTE_W-1:0]     byte_out_i,
  input logic                            is_error_i,
  input logic                            last_i
);

  logic out_acc;
  logic err_seen_q;
  logic nonlast_q;

  assign out_acc = out_valid_i && out_ready_i;

  // Remember whether an error went out and whether the previous result
  // left its request open.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
      nonlast_q  <= 1'b0;
    end else if (out_acc) begin
      err_seen_q <= err_seen_q || is_error_i;
      nonlast_q  <= !last_i;
    end
  end

  `LFBP_ASSERT(a_err_shape, out_valid_i && is_error_i |-> last_i && (byte_out_i == '0))
  `LFBP_ASSERT(a_err_sticky, out_valid_i && err_seen_q |-> is_error_i)
  `LFBP_ASSERT_NEVER(a_three_results, out_valid_i && nonlast_q && !last_i)
  `LFBP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_out_i) && $stable(is_error_i) && $stable(last_i))

endmodule

bind lsb_first_bit_packer lfbp_checker u_lfbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .byte_out_i  (byte_out_o),
  .is_error_i  (is_error_o),
  .last_i      (last_o)
);

@@ dv/lfbp_byte_checker.sv @@
`default_nettype none

// Watches both channels of the bit packer, predicts the byte stream from the
// accepted requests and compares every result in order.
module lfbp_byte_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lfbp_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire logic [lfbp_pkg::CODE_W-1:0]  code_bits_i,
  input  wire logic [lfbp_pkg::LEN_W-1:0]   code_length_i,
  input  wire logic                         reverse_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic [lfbp_pkg::BYTE_W-1:0]  byte_out_i,
  input  wire logic                         is_error_i,
  input  wire logic                         last_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfbp_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              err;
    logic              last;
  } out_byte_t;

  out_byte_t         expected_bytes[$];
  logic [ACC_W-1:0]  held_bits;
  int unsigned       held_count;
  logic [CAP_W-1:0]  bytes_sent;
  logic [CAP_W-1:0]  capacity;
  logic              full_seen;
  int unsigned       mismatches;

  // Appends one request to the model of the packer and queues the results it
  // produces: up to two bytes, the last replaced by an error once the capacity is hit.
  function automatic void pack_request(logic [CODE_W-1:0] code, logic [LEN_W-1:0] len_in,
                                       logic rev);
    int unsigned       len;
    int unsigned       made;
    logic [CODE_W-1:0] bits;
    out_byte_t         made_bytes[2];
    if (full_seen) begin
      expected_bytes.push_back('{data: '0, err: 1'b1, last: 1'b1});
      return;
    end
    len = (int'(len_in) > LEN_LIMIT) ? LEN_LIMIT : int'(len_in);
    if (len == 0) return;
    bits = '0;
    for (int i = 0; i < len; i++) begin
      bits[i] = rev ? code[len - 1 - i] : code[i];
    end
    held_bits  = held_bits | (ACC_W'(bits) << held_count);
    held_count = held_count + len;
    made = 0;
    while (held_count >= 8) begin
      if (bytes_sent >= capacity) begin
        // The pending bits stay in the accumulator; later requests are dropped.
        full_seen = 1'b1;
        made_bytes[made] = '{data: '0, err: 1'b1, last: 1'b1};
        made++;
        break;
      end
      made_bytes[made] = '{data: held_bits[7:0], err: 1'b0, last: 1'b0};
      made++;
      bytes_sent = bytes_sent + 1'b1;
      held_count = held_count - 8;
      held_bits  = held_bits >> 8;
    end
    if (made > 0) made_bytes[made - 1].last = 1'b1;
    for (int i = 0; i < made; i++) expected_bytes.push_back(made_bytes[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_byte_t want;
    if (!rst_ni) begin
      expected_bytes.delete();
      held_bits    = '0;
      held_count   = 0;
      bytes_sent   = '0;
      capacity     = CAP_RESET;
      full_seen    = 1'b0;
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Results are compared before new requests are queued, so a result can
      // never be matched against a request accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: byte_out %02h is_error %0b last %0b",
                   $time, byte_out_i, is_error_i, last_i);
        end else begin
          want = expected_bytes.pop_front();
          if (byte_out_i !== want.data) begin
            mismatches++;
            $display("%0t: byte_out expected %02h actual %02h", $time, want.data, byte_out_i);
          end
          if (is_error_i !== want.err) begin
            mismatches++;
            $display("%0t: is_error expected %0b actual %0b", $time, want.err, is_error_i);
          end
          if (last_i !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, last_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) pack_request(code_bits_i, code_length_i, reverse_i);
      if (cfg_we_i) capacity = cfg_wdata_i;
      fail_count_o <= mismatches;
      pending_o    <= expected_bytes.size();
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_lsb_first_bit_packer.sv @@
`default_nettype none

// Top of the bit packer testbench. It drives requests and capacity writes,
// paces the result channel and gives the verdict; all prediction and
// comparison lives in the checker beside the block.
module tb_lsb_first_bit_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import lfbp_pkg::*;

  // Cycles to let pass after the last expected result before touching the
  // capacity or ending the run. A request that completes no byte leaves
  // nothing in flight, so this leaves a wide margin.
  localparam int unsigned DRAIN_CYCLES = 8;
  // The slowest correct run is roughly 450 requests, each with the longest idle
  // gap on the input and two results each waiting out the longest stall; the
  // limit is many times that.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 120;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [CODE_W-1:0]  code_bits_i   = '0;
  logic [LEN_W-1:0]   code_length_i = '0;
  logic               reverse_i     = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [BYTE_W-1:0]  byte_out_o;
  logic               is_error_o;
  logic               last_o;

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        cycle_count = 0;
  // Total of appended bits, used only to place the capacity close to the
  // current byte count in the last phase.
  int unsigned        bits_total  = 0;
  // While a quiet flag is set that side runs without idle cycles.
  bit                 in_quiet    = 1'b0;
  bit                 out_quiet   = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  lsb_first_bit_packer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .reverse_i     (reverse_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_out_o    (byte_out_o),
    .is_error_o    (is_error_o),
    .last_o        (last_o)
  );

  lfbp_byte_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .reverse_i     (reverse_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_out_i    (byte_out_o),
    .is_error_i    (is_error_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Presents one request and returns in the time step of the edge that
  // accepts it. It must be called in the time step of a rising edge. With no
  // idle cycles drawn, valid simply stays high and the payload moves on, so
  // valid is never lowered and raised within one step.
  task automatic send_request(input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                              input logic rev);
    int unsigned gap;
    if ($urandom_range(0, 24) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    code_bits_i   <= code;
    code_length_i <= len;
    reverse_i     <= rev;
    do @(posedge clk_i); while (!in_ready_o);
    bits_total += (int'(len) > LEN_LIMIT) ? LEN_LIMIT : int'(len);
  endtask

  // A random request: mostly legal lengths, some zero-length requests and
  // some lengths above 16 that the block has to saturate.
  task automatic send_random_request();
    int unsigned      pick;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = '0;
    else if (pick == 1) len = LEN_W'($urandom_range(LEN_LIMIT + 1, (1 << LEN_W) - 1));
    else len = LEN_W'($urandom_range(1, LEN_LIMIT));
    send_request(CODE_W'($urandom), len, 1'($urandom_range(0, 1)));
  endtask

  // Waits until the block is idle, then writes the capacity register. The
  // first edge lets the checker count a request accepted in this step.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: before each result it draws a stall, then holds ready high
  // until a result is taken.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 24) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 11);
      if (stall == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int cap_next;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests with the capacity left at its reset value.
    send_request(16'hFFFF, 5'd0, 1'b0);   // Zero length gives no result.
    send_request(16'h00A5, 5'd8, 1'b0);   // Exactly one byte.
    send_request(16'hFFA5, 5'd8, 1'b1);   // Upper bits ignored, low byte mirrored.
    send_request(16'hFFFF, 5'd16, 1'b0);  // Two bytes of ones.
    send_request(16'h0000, 5'd16, 1'b1);  // Two zero bytes.
    send_request(16'h0001, 5'd1, 1'b0);   // Short codes that build one byte.
    send_request(16'h0005, 5'd3, 1'b1);
    send_request(16'h000C, 5'd4, 1'b0);
    send_request(16'h1234, 5'd17, 1'b0);  // Lengths above 16 saturate.
    send_request(16'hFFFF, 5'd31, 1'b1);
    send_request(16'h8001, 5'd24, 1'b0);
    send_request(16'h007F, 5'd7, 1'b0);   // Seven bits pending afterwards.
    send_request(16'h01FF, 5'd9, 1'b1);
    send_request(16'h5555, 5'd15, 1'b1);
    send_request(16'h0000, 5'd1, 1'b0);
    send_request(16'hAAAA, 5'd16, 1'b1);
    send_request(16'h0000, 5'd0, 1'b1);
    send_request(16'h0002, 5'd2, 1'b0);
    send_request(16'h0015, 5'd5, 1'b1);
    send_request(16'hC3C3, 5'd16, 1'b0);  // 23 bits held: two bytes, seven left.

    // Random phases with capacities far above the bytes this run can emit.
    write_capacity(16'hFFFF);
    repeat (PHASE_ITEMS) send_random_request();
    write_capacity(CAP_W'($urandom_range(4096, 65534)));
    repeat (PHASE_ITEMS) send_random_request();
    write_capacity(16'd4096);
    repeat (PHASE_ITEMS) send_random_request();

    // Place the capacity near the current byte count, sometimes below it, so
    // that it is reached at a random point, then keep sending while full.
    cap_next = int'(bits_total / 8) + int'($urandom_range(0, 28)) - 4;
    if (cap_next < 0) cap_next = 0;
    write_capacity(CAP_W'(cap_next));
    repeat (60) send_random_request();

    // A new capacity does not clear the full state; zero length still errors.
    write_capacity(16'd0);
    send_request(16'h0000, 5'd0, 1'b0);
    write_capacity(16'hFFFF);
    send_request(16'hFFFF, 5'd0, 1'b1);
    repeat (8) send_random_request();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/lfbp_pkg.sv
rtl/lfbp_queue.sv
rtl/lfbp_front.sv
rtl/lfbp_back.sv
rtl/lsb_first_bit_packer.sv
rtl/lfbp_checker.sv
dv/lfbp_byte_checker.sv
dv/tb_lsb_first_bit_packer.sv
